// ===== rtl/core/sorted_software_timer_queue_top_defines.svh =====
// Assertion macros for the sorted software timer queue.
// Used by the checker bound to sorted_software_timer_queue_top; needs no other file.
`ifndef SORTED_SOFTWARE_TIMER_QUEUE_TOP_DEFINES_SVH
`define SORTED_SOFTWARE_TIMER_QUEUE_TOP_DEFINES_SVH

// Checked at every clock edge outside reset.
`define STQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, also during reset.
`define STQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/stq_pkg.sv =====
// Shared types and codes of the sorted software timer queue.
// Used by stq_cell, sorted_software_timer_queue_top and stq_checker; depends on nothing.
package stq_pkg;

   localparam int NUM_SLOTS_DEFAULT = 16;
   localparam int MAX_FIRES_DEFAULT = 63;
   // Slot index width inside the cell row, wide enough for the largest row.
   localparam int IDX_W = 8;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [1:0] KIND_FIRE   = 2'd0;
   localparam logic [1:0] KIND_CALL   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  timer_id;
      logic [31:0] due_delay;
      logic [31:0] repeat_period;
      logic [31:0] user_value;
      logic        call_now;
      logic [63:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  slot;
      logic [31:0] handed_value;
      logic        is_armed;
      logic        has_fired;
      logic        more_pending;
      logic        last;
   } rsp_type;

   // Command broadcast from the controller to the cell row.
   typedef struct packed {
      logic             start;
      logic             stop;
      logic             fire;
      logic [IDX_W-1:0] idx;
      logic [63:0]      due;
      logic [31:0]      period;
      logic [31:0]      value;
      logic [31:0]      stamp;
   } cmd_type;

   // Best due slot so far, handed from cell to cell.
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
      logic [63:0]      due;
      logic [31:0]      stamp;
      logic [31:0]      period;
      logic [31:0]      value;
      logic             fired;
   } cand_type;

   // Readout of one cell for stop and status.
   typedef struct packed {
      logic        armed;
      logic        fired;
      logic [31:0] period;
      logic [31:0] value;
   } stat_type;

endpackage

// ===== rtl/core/stq_cell.sv =====
// One timer slot of the cell row: slot state plus one stage of the earliest-due search.
// Depends on stq_pkg.
module stq_cell #(
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  stq_pkg::cmd_type   cmd,
   input  logic [63:0]        cur_time,
   input  stq_pkg::cand_type  cand_prev,
   output stq_pkg::cand_type  cand_next,
   output stq_pkg::stat_type  stat
);

   logic [63:0] due_ff, due_in;
   logic [31:0] period_ff, period_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] stamp_ff, stamp_in;
   logic        armed_ff, armed_in;
   logic        fired_ff, fired_in;
   stq_pkg::cand_type cand_ff, cand_in;
   logic hit;
   logic eligible;
   logic better;

   assign hit = (cmd.idx == stq_pkg::IDX_W'(INDEX));

   always_comb begin
      due_in    = due_ff;
      period_in = period_ff;
      value_in  = value_ff;
      stamp_in  = stamp_ff;
      armed_in  = armed_ff;
      fired_in  = fired_ff;
      if (hit && cmd.start) begin
         due_in    = cmd.due;
         period_in = cmd.period;
         value_in  = cmd.value;
         stamp_in  = cmd.stamp;
         armed_in  = 1'b1;
         fired_in  = 1'b0;
      end else if (hit && cmd.stop) begin
         armed_in = 1'b0;
      end else if (hit && cmd.fire) begin
         if (period_ff != 32'd0) begin
            due_in   = due_ff + 64'(period_ff);
            stamp_in = cmd.stamp;
         end else begin
            armed_in = 1'b0;
            fired_in = 1'b1;
         end
      end
   end

   // The incoming candidate comes from lower slots, so a full tie keeps it.
   assign eligible = armed_ff && (due_ff < cur_time);
   assign better   = !cand_prev.found || (due_ff < cand_prev.due) ||
                     ((due_ff == cand_prev.due) && (stamp_ff > cand_prev.stamp));

   always_comb begin
      cand_in = cand_prev;
      if (eligible && better) begin
         cand_in.found  = 1'b1;
         cand_in.idx    = stq_pkg::IDX_W'(INDEX);
         cand_in.due    = due_ff;
         cand_in.stamp  = stamp_ff;
         cand_in.period = period_ff;
         cand_in.value  = value_ff;
         cand_in.fired  = fired_ff;
      end
   end

   always_ff @(posedge clock) begin
      due_ff    <= due_in;
      period_ff <= period_in;
      value_ff  <= value_in;
      stamp_ff  <= stamp_in;
      if (reset) begin
         armed_ff <= 1'b0;
         fired_ff <= 1'b0;
         cand_ff  <= '0;
      end else begin
         armed_ff <= armed_in;
         fired_ff <= fired_in;
         cand_ff  <= cand_in;
      end
   end

   assign cand_next    = cand_ff;
   assign stat.armed   = armed_ff;
   assign stat.fired   = fired_ff;
   assign stat.period  = period_ff;
   assign stat.value   = value_ff;

endmodule

// ===== rtl/core/sorted_software_timer_queue_top.sv =====
// Top level of the sorted software timer queue: controller, result register, cell row.
// Depends on stq_pkg and stq_cell.
//
// The block keeps NUM_SLOTS timer slots in a row of cells, one slot per cell.
// A start item and a stop item each pass through ST_PROC and ST_STATUS,
// each ending in one status item on the result channel (a stop with call_now
// on an armed one-shot slot gives a call item first). A tick item whose count
// changes searches for the earliest due slot by handing a candidate down the
// cell row, one cell per cycle; the search is repeated after each firing, up to
// MAX_FIRES_PER_TICK fires, after which more_pending is set if a due slot remains.
// One item is worked on at a time; req_stall is high until its status item has
// been loaded into the result register, which may still wait for the receiver
// while the next item is accepted. Results stall only while rsp_stall is high.
module sorted_software_timer_queue_top #(
   parameter int NUM_SLOTS          = stq_pkg::NUM_SLOTS_DEFAULT,
   parameter int MAX_FIRES_PER_TICK = stq_pkg::MAX_FIRES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stq_pkg::rsp_type rsp_payload
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int FIRE_W = $clog2(MAX_FIRES_PER_TICK + 1);

   // One-hot controller states.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PROC   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_STATUS = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   stq_pkg::req_type req_ff, req_in;
   logic [63:0]       cur_ff, cur_in;
   logic [31:0]       stamp_ff, stamp_in;
   logic [FIRE_W-1:0] fires_ff, fires_in;
   logic              more_ff, more_in;
   logic [SLOT_W-1:0] scan_ff, scan_in;
   logic              rsp_valid_ff, rsp_valid_in;
   stq_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   stq_pkg::cmd_type  cmd;
   stq_pkg::cand_type cand_chain [NUM_SLOTS+1];
   stq_pkg::stat_type stat_row [NUM_SLOTS];
   stq_pkg::stat_type sel;
   stq_pkg::cand_type best;
   logic              id_valid;
   logic [SLOT_W-1:0] id_idx;
   logic              out_free;

   // The row starts from an empty candidate; the last cell gives the winner.
   assign cand_chain[0] = '0;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      stq_cell #(
         .INDEX(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .cur_time  (cur_ff),
         .cand_prev (cand_chain[i]),
         .cand_next (cand_chain[i+1]),
         .stat      (stat_row[i])
      );
   end

   assign best     = cand_chain[NUM_SLOTS];
   assign id_valid = (32'(req_ff.timer_id) < NUM_SLOTS);
   assign id_idx   = SLOT_W'(req_ff.timer_id);
   assign sel      = id_valid ? stat_row[id_idx] : '0;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      stamp_in     = stamp_ff;
      fires_in     = fires_ff;
      more_in      = more_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               more_in  = 1'b0;
               state_in = ST_PROC;
            end
         end
         ST_PROC: begin
            if (out_free) begin
               state_in = ST_STATUS;
               case (req_ff.operation)
                  stq_pkg::OP_START: begin
                     if (id_valid) begin
                        cmd.start  = 1'b1;
                        cmd.idx    = stq_pkg::IDX_W'(req_ff.timer_id);
                        cmd.due    = cur_ff + 64'(req_ff.due_delay);
                        cmd.period = req_ff.repeat_period;
                        cmd.value  = req_ff.user_value;
                        cmd.stamp  = stamp_ff;
                        stamp_in   = stamp_ff + 32'd1;
                     end
                  end
                  stq_pkg::OP_STOP: begin
                     if (id_valid && sel.armed) begin
                        cmd.stop = 1'b1;
                        cmd.idx  = stq_pkg::IDX_W'(req_ff.timer_id);
                        if (req_ff.call_now && (sel.period == 32'd0)) begin
                           rsp_valid_in              = 1'b1;
                           rsp_data_in.kind          = stq_pkg::KIND_CALL;
                           rsp_data_in.slot          = req_ff.timer_id;
                           rsp_data_in.handed_value  = sel.value;
                           rsp_data_in.is_armed      = 1'b0;
                           rsp_data_in.has_fired     = sel.fired;
                           rsp_data_in.more_pending  = 1'b0;
                           rsp_data_in.last          = 1'b0;
                        end
                     end
                  end
                  stq_pkg::OP_TICK: begin
                     if (req_ff.now_ms != cur_ff) begin
                        cur_in   = (req_ff.now_ms < cur_ff) ? 64'd0 : req_ff.now_ms;
                        fires_in = '0;
                        scan_in  = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_STATUS;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Wait until the candidate has passed every cell.
            if (scan_ff == SLOT_W'(NUM_SLOTS - 1)) begin
               state_in = ST_DECIDE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            if (!best.found) begin
               state_in = ST_STATUS;
            end else if (fires_ff >= FIRE_W'(MAX_FIRES_PER_TICK)) begin
               more_in  = 1'b1;
               state_in = ST_STATUS;
            end else if (out_free) begin
               cmd.fire  = 1'b1;
               cmd.idx   = best.idx;
               cmd.stamp = stamp_ff;
               if (best.period != 32'd0) begin
                  stamp_in = stamp_ff + 32'd1;
               end
               rsp_valid_in             = 1'b1;
               rsp_data_in.kind         = stq_pkg::KIND_FIRE;
               rsp_data_in.slot         = 4'(best.idx);
               rsp_data_in.handed_value = best.value;
               rsp_data_in.is_armed     = (best.period != 32'd0);
               rsp_data_in.has_fired    = (best.period == 32'd0) || best.fired;
               rsp_data_in.more_pending = 1'b0;
               rsp_data_in.last         = 1'b0;
               fires_in = fires_ff + 1'b1;
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.kind         = stq_pkg::KIND_STATUS;
               rsp_data_in.slot         = req_ff.timer_id;
               rsp_data_in.handed_value = sel.value;
               rsp_data_in.is_armed     = sel.armed;
               rsp_data_in.has_fired    = sel.fired;
               rsp_data_in.more_pending = more_ff;
               rsp_data_in.last         = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= 64'd0;
         stamp_ff     <= 32'd0;
         fires_ff     <= '0;
         more_ff      <= 1'b0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         stamp_ff     <= stamp_in;
         fires_ff     <= fires_in;
         more_ff      <= more_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== rtl/core/stq_checker.sv =====
// Port-level checks of the sorted software timer queue, bound to its top level.
// Depends on stq_pkg and sorted_software_timer_queue_top_defines.svh.
`include "sorted_software_timer_queue_top_defines.svh"

module stq_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input stq_pkg::rsp_type rsp_payload
);

   `STQ_ASSERT_ALWAYS(a_rsp_quiet_after_reset, reset |=> !rsp_valid, "valid after reset")
   `STQ_ASSERT(a_rsp_valid_holds, rsp_valid && rsp_stall |=> rsp_valid, "stalled item dropped")
   `STQ_ASSERT(a_rsp_payload_holds, rsp_valid && rsp_stall |=> $stable(rsp_payload), "item changed")
   `STQ_ASSERT(a_last_on_status, rsp_valid |-> ((rsp_payload.kind == stq_pkg::KIND_STATUS) == rsp_payload.last), "bad last")
   `STQ_ASSERT(a_more_on_status, rsp_valid && (rsp_payload.kind != stq_pkg::KIND_STATUS) |-> !rsp_payload.more_pending, "bad more")

endmodule

bind sorted_software_timer_queue_top stq_checker u_stq_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
